// ===== sv/dpt_pkg.sv =====
`timescale 1ns / 1ps

package dpt_pkg;

  // Node pool size and derived index width
  localparam int NODE_COUNT   = 4096;
  localparam int IDX_W        = $clog2(NODE_COUNT);
  localparam int LANES        = 4;
  localparam int SYM_W        = 8;
  localparam int STATUS_W     = 3;
  localparam int NODES_USED_W = 12;

  // Letter codes
  localparam logic [SYM_W-1:0] SYM_A = 8'h41;
  localparam logic [SYM_W-1:0] SYM_C = 8'h43;
  localparam logic [SYM_W-1:0] SYM_G = 8'h47;
  localparam logic [SYM_W-1:0] SYM_T = 8'h54;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_PENDING = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd4;

  // Word failure codes
  localparam logic [1:0] FAIL_NONE    = 2'd0;
  localparam logic [1:0] FAIL_ABSENT  = 2'd1;
  localparam logic [1:0] FAIL_FULL    = 2'd2;
  localparam logic [1:0] FAIL_INVALID = 2'd3;

  // Item kind
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  // Memory requests from the controller
  typedef struct packed {
    logic                   link_re;
    logic [IDX_W-1:0]       link_raddr;
    logic [LANES-1:0]       link_we;
    logic [IDX_W-1:0]       link_waddr;
    logic [IDX_W-1:0]       link_wdata;
    logic                   term_re;
    logic [IDX_W-1:0]       term_raddr;
    logic                   term_we;
    logic [IDX_W-1:0]       term_waddr;
    logic                   term_wdata;
  } mem_req_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] slot;
  } slot_t;

  // Letter to child slot
  function automatic slot_t letter_slot(input logic [SYM_W-1:0] sym);
    slot_t r;
    r.ok   = 1'b1;
    r.slot = 2'd0;
    case (sym)
      SYM_A:   r.slot = 2'd0;
      SYM_C:   r.slot = 2'd1;
      SYM_G:   r.slot = 2'd2;
      SYM_T:   r.slot = 2'd3;
      default: r.ok   = 1'b0;
    endcase
    return r;
  endfunction

  // Failure code to result status
  function automatic logic [STATUS_W-1:0] fail_status(input logic [1:0] f);
    logic [STATUS_W-1:0] s;
    case (f)
      FAIL_ABSENT:  s = ST_ABSENT;
      FAIL_FULL:    s = ST_FULL;
      FAIL_INVALID: s = ST_INVALID;
      default:      s = ST_PENDING;
    endcase
    return s;
  endfunction

endpackage

// ===== sv/dpt_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read port
module dpt_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/dpt_ctrl.sv =====
`timescale 1ns / 1ps

module dpt_ctrl
  import dpt_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         kind_i,
  input  logic [SYM_W-1:0]             symbol_i,
  input  logic                         last_symbol_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [STATUS_W-1:0]          status_o,
  output logic                         word_done_o,
  output logic [NODES_USED_W-1:0]      nodes_used_o,
  output mem_req_t                     mem_o,
  input  logic [LANES-1:0][IDX_W-1:0]  link_rdata_i,
  input  logic                         term_rdata_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_TERM  = 3'd2;
  localparam logic [2:0] S_ALLOC = 3'd3;
  localparam logic [2:0] S_FAIL  = 3'd4;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_COUNT - 1);

  logic [2:0]             state_q, state_d;
  logic [IDX_W-1:0]       cur_q, cur_d;
  logic [IDX_W-1:0]       count_q, count_d;
  logic [1:0]             failed_q, failed_d;
  logic [LANES-1:0]       root_ok_q, root_ok_d;
  logic                   kind_q;
  logic                   last_q;
  logic [1:0]             slot_q;
  logic                   sym_ok_q;

  logic                   out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]    status_q;
  logic                   done_q;
  logic [NODES_USED_W-1:0] used_q;

  logic                   out_free;
  logic                   fin;
  logic                   go;
  logic [STATUS_W-1:0]    res_status;
  logic [IDX_W-1:0]       nxt;
  slot_t                  dec;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign dec        = letter_slot(symbol_i);
  assign go         = fin && out_free;

  // Child link, root lanes read as null until first written
  always_comb begin
    nxt = link_rdata_i[slot_q];
    if (cur_q == '0 && !root_ok_q[slot_q]) begin
      nxt = '0;
    end
  end

  // Per-symbol sequencing
  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    count_d    = count_q;
    failed_d   = failed_q;
    root_ok_d  = root_ok_q;
    fin        = 1'b0;
    res_status = ST_PENDING;
    mem_o      = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (failed_q != FAIL_NONE || !dec.ok) begin
            state_d = S_FAIL;
          end else begin
            mem_o.link_re    = 1'b1;
            mem_o.link_raddr = cur_q;
            state_d          = S_LOOK;
          end
        end
      end

      S_FAIL: begin
        fin = 1'b1;
        if (failed_q == FAIL_NONE) begin
          failed_d = (kind_q == KIND_SEARCH) ? FAIL_ABSENT : FAIL_INVALID;
        end
        res_status = fail_status(failed_d);
      end

      S_LOOK: begin
        if (kind_q == KIND_SEARCH) begin
          if (nxt == '0) begin
            fin        = 1'b1;
            failed_d   = FAIL_ABSENT;
            res_status = ST_ABSENT;
          end else if (last_q) begin
            // terminal flag of the node reached needs its own read
            cur_d            = nxt;
            mem_o.term_re    = 1'b1;
            mem_o.term_raddr = nxt;
            state_d          = S_TERM;
          end else begin
            fin   = 1'b1;
            cur_d = nxt;
          end
        end else begin
          if (nxt == '0) begin
            if (count_q == LAST_IDX) begin
              fin        = 1'b1;
              failed_d   = FAIL_FULL;
              res_status = ST_FULL;
            end else begin
              // link parent lane to the new node, then clear the node
              count_d                  = count_q + 1'b1;
              mem_o.link_we[slot_q]    = 1'b1;
              mem_o.link_waddr         = cur_q;
              mem_o.link_wdata         = count_d;
              if (cur_q == '0) begin
                root_ok_d[slot_q] = 1'b1;
              end
              cur_d   = count_d;
              state_d = S_ALLOC;
            end
          end else begin
            fin   = 1'b1;
            cur_d = nxt;
            if (last_q) begin
              res_status       = ST_OK;
              mem_o.term_we    = out_free;
              mem_o.term_waddr = nxt;
              mem_o.term_wdata = 1'b1;
            end
          end
        end
      end

      S_TERM: begin
        fin        = 1'b1;
        res_status = term_rdata_i ? ST_OK : ST_ABSENT;
      end

      S_ALLOC: begin
        fin              = 1'b1;
        res_status       = last_q ? ST_OK : ST_PENDING;
        mem_o.link_we    = '1;
        mem_o.link_waddr = cur_q;
        mem_o.link_wdata = '0;
        mem_o.term_we    = 1'b1;
        mem_o.term_waddr = cur_q;
        mem_o.term_wdata = last_q;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Finish: hold until the output slot is free
    if (fin) begin
      if (out_free) begin
        state_d = S_IDLE;
        if (last_q) begin
          cur_d    = '0;
          failed_d = FAIL_NONE;
        end
      end else begin
        cur_d    = cur_q;
        failed_d = failed_q;
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (go) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      count_q     <= '0;
      failed_q    <= FAIL_NONE;
      root_ok_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      count_q     <= count_d;
      failed_q    <= failed_d;
      root_ok_q   <= root_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Item and result payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q   <= kind_i;
      last_q   <= last_symbol_i;
      slot_q   <= dec.slot;
      sym_ok_q <= dec.ok;
    end
    if (go) begin
      status_q <= res_status;
      done_q   <= last_q;
      used_q   <= NODES_USED_W'(count_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign word_done_o  = done_q;
  assign nodes_used_o = used_q;

`ifndef NO_ASSERTIONS
  // Node count only grows
  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> count_q >= $past(count_q))
    else $error("node count decreased");

  // Cursor never points past the allocated nodes
  a_cur_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= count_q)
    else $error("cursor beyond allocated nodes");

  // Link memory is never read and written in the same cycle
  a_link_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_o.link_re && (mem_o.link_we != '0)))
    else $error("link memory read and write overlap");

  // Lookup only runs on a valid letter with no prior failure
  a_look_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOOK |-> sym_ok_q && failed_q == FAIL_NONE)
    else $error("lookup on failed word or invalid letter");

  // A new node is never the root
  a_alloc_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ALLOC |-> cur_q != '0)
    else $error("allocated node aliases the root");
`endif

endmodule

// ===== sv/dna_prefix_trie_insert_search_top.sv =====
`timescale 1ns / 1ps
// A symbol is taken in S_IDLE, then looked up in S_LOOK; an allocating insert goes on to
// S_ALLOC, and the last symbol of a search to S_TERM (second memory read). No new symbol
// is taken until the last one's result is registered, which waits for a free output slot.
// Reset (rst_ni, async, active low) empties the trie at once: root lanes carry valid flops,
// other nodes are cleared when allocated, so no clearing pass is needed.
module dna_prefix_trie_insert_search_top
  import dpt_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    kind_i,
  input  logic [SYM_W-1:0]        symbol_i,
  input  logic                    last_symbol_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [STATUS_W-1:0]     status_o,
  output logic                    word_done_o,
  output logic [NODES_USED_W-1:0] nodes_used_o
);

  mem_req_t                    mem_req;
  logic [LANES-1:0][IDX_W-1:0] link_rdata;
  logic                        term_rdata;

  dpt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .symbol_i     (symbol_i),
    .last_symbol_i(last_symbol_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .word_done_o  (word_done_o),
    .nodes_used_o (nodes_used_o),
    .mem_o        (mem_req),
    .link_rdata_i (link_rdata),
    .term_rdata_i (term_rdata)
  );

  // Child links, one lane per letter
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    dpt_ram #(
      .WIDTH(IDX_W),
      .DEPTH(NODE_COUNT)
    ) u_link (
      .clk_i  (clk_i),
      .we_i   (mem_req.link_we[l]),
      .waddr_i(mem_req.link_waddr),
      .wdata_i(mem_req.link_wdata),
      .re_i   (mem_req.link_re),
      .raddr_i(mem_req.link_raddr),
      .rdata_o(link_rdata[l])
    );
  end

  // Terminal flags
  dpt_ram #(
    .WIDTH(1),
    .DEPTH(NODE_COUNT)
  ) u_term (
    .clk_i  (clk_i),
    .we_i   (mem_req.term_we),
    .waddr_i(mem_req.term_waddr),
    .wdata_i(mem_req.term_wdata),
    .re_i   (mem_req.term_re),
    .raddr_i(mem_req.term_raddr),
    .rdata_o(term_rdata)
  );

endmodule

// ===== dv/tb_dna_prefix_trie_insert_search_top.sv =====
`timescale 1ns / 1ps

module tb_dna_prefix_trie_insert_search_top;
  import dpt_pkg::*;

  // Clock, reset and block ports
  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    in_valid_i    = 1'b0;
  logic                    in_ready_o;
  logic                    kind_i        = KIND_INSERT;
  logic [SYM_W-1:0]        symbol_i      = SYM_A;
  logic                    last_symbol_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i   = 1'b0;
  logic [STATUS_W-1:0]     status_o;
  logic                    word_done_o;
  logic [NODES_USED_W-1:0] nodes_used_o;

  dna_prefix_trie_insert_search_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .symbol_i     (symbol_i),
    .last_symbol_i(last_symbol_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .word_done_o  (word_done_o),
    .nodes_used_o (nodes_used_o)
  );

  always #2 clk_i = ~clk_i;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic                    word_done;
    logic [NODES_USED_W-1:0] nodes_used;
  } trie_result_t;

  // Expected results, oldest first
  trie_result_t expected_results[$];
  int           err_cnt = 0;

  // Shadow trie
  logic [IDX_W-1:0] trie_link [NODE_COUNT][LANES];
  logic             trie_term [NODE_COUNT];
  int unsigned      trie_count;
  logic [IDX_W-1:0] trie_cursor;
  logic [1:0]       trie_fail;

  // Sender and receiver control
  bit gap_enable   = 1'b1;
  int burst_left   = 0;
  bit pressure_req = 1'b0;

  // Word under construction
  logic             wbuf_kind [64];
  logic [SYM_W-1:0] wbuf_sym  [64];

  // Words inserted during the random phase
  logic [SYM_W-1:0] known_sym [128][8];
  int               known_len [128];
  int               known_n = 0;

  function automatic void trie_clear();
    for (int n = 0; n < NODE_COUNT; n++) begin
      for (int l = 0; l < LANES; l++) trie_link[n][l] = '0;
      trie_term[n] = 1'b0;
    end
    trie_count  = 0;
    trie_cursor = '0;
    trie_fail   = FAIL_NONE;
  endfunction

  function automatic int lane_of(input logic [SYM_W-1:0] sym);
    int lane;
    case (sym)
      SYM_A:   lane = 0;
      SYM_C:   lane = 1;
      SYM_G:   lane = 2;
      SYM_T:   lane = 3;
      default: lane = -1;
    endcase
    return lane;
  endfunction

  // Advance the shadow trie by one symbol and return its result
  function automatic trie_result_t trie_walk(input logic kind, input logic [SYM_W-1:0] sym,
                                             input logic last);
    trie_result_t     r;
    int               lane;
    logic [IDX_W-1:0] cur;
    logic [IDX_W-1:0] nxt;
    r.status = ST_PENDING;
    cur      = trie_cursor;
    if (trie_fail == FAIL_NONE) begin
      lane = lane_of(sym);
      if (lane < 0) begin
        trie_fail = (kind == KIND_SEARCH) ? FAIL_ABSENT : FAIL_INVALID;
      end else if (kind == KIND_SEARCH) begin
        nxt = trie_link[cur][lane];
        if (nxt == '0) begin
          trie_fail = FAIL_ABSENT;
        end else begin
          cur = nxt;
          if (last) r.status = trie_term[cur] ? ST_OK : ST_ABSENT;
        end
      end else begin
        nxt = trie_link[cur][lane];
        if (nxt == '0) begin
          if (trie_count >= NODE_COUNT - 1) begin
            trie_fail = FAIL_FULL;
          end else begin
            trie_count++;
            nxt = trie_count[IDX_W-1:0];
            for (int l = 0; l < LANES; l++) trie_link[nxt][l] = '0;
            trie_term[nxt]        = 1'b0;
            trie_link[cur][lane]  = nxt;
          end
        end
        if (trie_fail == FAIL_NONE) begin
          cur = nxt;
          if (last) begin
            trie_term[cur] = 1'b1;
            r.status       = ST_OK;
          end
        end
      end
      trie_cursor = cur;
    end
    case (trie_fail)
      FAIL_ABSENT:  r.status = ST_ABSENT;
      FAIL_FULL:    r.status = ST_FULL;
      FAIL_INVALID: r.status = ST_INVALID;
      default:      ;
    endcase
    r.word_done  = last;
    r.nodes_used = trie_count[NODES_USED_W-1:0];
    if (last) begin
      trie_cursor = '0;
      trie_fail   = FAIL_NONE;
    end
    return r;
  endfunction

  function automatic logic [SYM_W-1:0] rand_letter();
    logic [SYM_W-1:0] s;
    case ($urandom_range(0, 3))
      0:       s = SYM_A;
      1:       s = SYM_C;
      2:       s = SYM_G;
      default: s = SYM_T;
    endcase
    return s;
  endfunction

  function automatic logic [SYM_W-1:0] rand_bad_symbol();
    logic [SYM_W-1:0] s;
    s = SYM_A;
    while (lane_of(s) >= 0) s = SYM_W'($urandom_range(0, 255));
    return s;
  endfunction

  // One symbol transfer, with bursts and gaps on the input side
  task automatic send_symbol(input logic kind, input logic [SYM_W-1:0] sym, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = gap_enable ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    symbol_i      <= sym;
    last_symbol_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_results.push_back(trie_walk(kind, sym, last));
  endtask

  task automatic send_buf(input int len);
    for (int i = 0; i < len; i++) send_symbol(wbuf_kind[i], wbuf_sym[i], i == len - 1);
  endtask

  task automatic send_text(input logic kind, input string w);
    for (int i = 0; i < w.len(); i++) begin
      wbuf_kind[i] = kind;
      wbuf_sym[i]  = w[i];
    end
    send_buf(w.len());
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  // Short directed words: empty trie, prefixes, bad letters, mixed kinds
  task automatic test_directed();
    send_text(KIND_SEARCH, "A");
    send_text(KIND_INSERT, "ACGT");
    send_text(KIND_SEARCH, "ACGT");
    send_text(KIND_SEARCH, "ACG");
    send_text(KIND_SEARCH, "ATG");
    send_text(KIND_INSERT, "AxC");
    send_symbol(KIND_INSERT, 8'h00, 1'b1);
    send_symbol(KIND_SEARCH, 8'hFF, 1'b1);
    send_text(KIND_SEARCH, "Ag");
    send_symbol(KIND_INSERT, SYM_G, 1'b0);
    send_symbol(KIND_SEARCH, SYM_T, 1'b1);
    send_symbol(KIND_SEARCH, SYM_A, 1'b0);
    send_symbol(KIND_INSERT, SYM_C, 1'b1);
    send_text(KIND_SEARCH, "AC");
    wait_drained();
  endtask

  // Mostly well-formed words, with searches of earlier inserts, plus noise
  task automatic test_random_words();
    int  n_items;
    int  pick;
    int  len;
    int  k;
    int  slot;
    int  cut;
    logic kind;
    bit  pressed;
    n_items = 0;
    pressed = 1'b0;
    while (n_items < 1400) begin
      gap_enable = ($urandom_range(0, 3) != 0);
      pick       = $urandom_range(0, 99);
      len        = $urandom_range(1, 7);
      if (pick < 35) begin
        for (int i = 0; i < len; i++) begin
          wbuf_kind[i] = KIND_INSERT;
          wbuf_sym[i]  = rand_letter();
        end
        if (known_n < 128) begin
          slot = known_n;
          known_n++;
        end else begin
          slot = $urandom_range(0, 127);
        end
        known_len[slot] = len;
        for (int i = 0; i < len; i++) known_sym[slot][i] = wbuf_sym[i];
      end else if (pick < 65 && known_n > 0) begin
        // earlier word, exact, cut short or extended by one letter
        k   = $urandom_range(0, known_n - 1);
        len = known_len[k];
        for (int i = 0; i < len; i++) begin
          wbuf_kind[i] = KIND_SEARCH;
          wbuf_sym[i]  = known_sym[k][i];
        end
        cut = $urandom_range(0, 9);
        if (cut < 2 && len > 1) begin
          len--;
        end else if (cut < 4) begin
          wbuf_kind[len] = KIND_SEARCH;
          wbuf_sym[len]  = rand_letter();
          len++;
        end
      end else if (pick < 80) begin
        for (int i = 0; i < len; i++) begin
          wbuf_kind[i] = KIND_SEARCH;
          wbuf_sym[i]  = rand_letter();
        end
      end else if (pick < 90) begin
        // broken word: one bad symbol somewhere
        kind = 1'($urandom_range(0, 1));
        for (int i = 0; i < len; i++) begin
          wbuf_kind[i] = kind;
          wbuf_sym[i]  = rand_letter();
        end
        wbuf_sym[$urandom_range(0, len - 1)] = rand_bad_symbol();
      end else begin
        // mixed kinds, any byte now and then
        for (int i = 0; i < len; i++) begin
          wbuf_kind[i] = 1'($urandom_range(0, 1));
          wbuf_sym[i]  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                      : rand_letter();
        end
      end
      send_buf(len);
      n_items += len;
      if (!pressed && n_items > 700) begin
        pressure_req = 1'b1;
        pressed      = 1'b1;
      end
    end
    wait_drained();
  endtask

  // Long fresh words that grow deep branches, a search of the last one, then short words
  task automatic test_long_words();
    for (int i = 0; i < 40; i++) wbuf_kind[i] = KIND_INSERT;
    pressure_req = 1'b1;
    for (int w = 0; w < 9; w++) begin
      gap_enable = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 40; i++) wbuf_sym[i] = rand_letter();
      send_buf(40);
    end
    for (int i = 0; i < 40; i++) wbuf_kind[i] = KIND_SEARCH;
    send_buf(40);
    for (int w = 0; w < 4; w++) begin
      for (int i = 0; i < 6; i++) begin
        wbuf_kind[i] = KIND_INSERT;
        wbuf_sym[i]  = rand_letter();
      end
      if (w == 1) wbuf_sym[4] = rand_bad_symbol();
      send_buf(6);
    end
    send_text(KIND_INSERT, "ACGT");
    send_text(KIND_SEARCH, "ACGT");
    send_text(KIND_SEARCH, "AC");
    send_text(KIND_INSERT, "AxC");
    wait_drained();
  endtask

  // Receiver: changing ready patterns, plus a long hold-off on request
  initial begin : sink_ctrl
    int cyc;
    int mode;
    cyc  = 0;
    mode = 0;
    forever begin
      @(posedge clk_i);
      if (pressure_req) begin
        pressure_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else begin
        if (cyc % 50 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= (cyc % 4 == 0);
          default: out_ready_i <= ($urandom_range(0, 9) != 0);
        endcase
        cyc++;
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin : result_check
    trie_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: status %0d word_done %0d nodes_used %0d",
               status_o, word_done_o, nodes_used_o);
        err_cnt++;
      end else begin
        exp_r = expected_results.pop_front();
        if (status_o !== exp_r.status) begin
          $error("status mismatch: expected %0d, actual %0d", exp_r.status, status_o);
          err_cnt++;
        end
        if (word_done_o !== exp_r.word_done) begin
          $error("word_done mismatch: expected %0d, actual %0d", exp_r.word_done,
                 word_done_o);
          err_cnt++;
        end
        if (nodes_used_o !== exp_r.nodes_used) begin
          $error("nodes_used mismatch: expected %0d, actual %0d", exp_r.nodes_used,
                 nodes_used_o);
          err_cnt++;
        end
      end
    end
  end

  // Test sequence
  initial begin
    trie_clear();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_words();
    test_long_words();
    repeat (20) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/dpt_pkg.sv
sv/dpt_ram.sv
sv/dpt_ctrl.sv
sv/dna_prefix_trie_insert_search_top.sv
dv/tb_dna_prefix_trie_insert_search_top.sv
